>>> rtl/core/bfp_pkg.sv
// ============================================================================
// bfp_pkg: shared types and codes of the bitstream field packer
// Command and status codes, and the chunk descriptor that the sequencer
// hands to the byte unit.
// ============================================================================
package bfp_pkg;

   typedef enum logic [2:0] {
      CMD_CLEAR = 3'd0,
      CMD_WRITE = 3'd1,
      CMD_READ  = 3'd2,
      CMD_SEEK  = 3'd3,
      CMD_ALIGN = 3'd4
   } cmd_type;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_READ_PAST = 2'd1;
   localparam logic [1:0] STATUS_SEEK_PAST = 2'd2;
   localparam logic [1:0] STATUS_WRITE_OVF = 2'd3;

   // One chunk of a field, bound to one byte of the store.
   typedef struct packed {
      logic       valid;
      logic       is_write;
      logic       fresh;     // byte lies at or beyond the stored length
      logic [2:0] off;       // first bit of the chunk within the byte
      logic [3:0] size;      // chunk bits, 1..8
      logic [7:0] piece;     // write chunk already placed at off
   } chunk_type;

   typedef struct packed {
      logic      acc_clear;
      chunk_type chunk;
   } byte_ctl_type;

endpackage

>>> rtl/core/bfp_ram.sv
// ============================================================================
// bfp_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ============================================================================
module bfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                                     clock,
   input  logic                                     wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                         wr_data,
   input  logic                                     rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/bfp_byte_unit.sv
// ============================================================================
// bfp_byte_unit: byte merge and field assembly
// Merges a write chunk into the byte read back from the store, or extracts a
// read chunk and shifts it into the field accumulator.
// ============================================================================
module bfp_byte_unit (
   input  logic                  clock,
   input  bfp_pkg::byte_ctl_type ctl,
   input  logic [7:0]            rd_data,
   output logic                  wr_en,
   output logic [7:0]            wr_data,
   output logic [63:0]           acc
);
   import bfp_pkg::*;

   logic [63:0] acc_ff;
   logic [63:0] acc_in;
   logic [7:0]  mask;
   logic [7:0]  ext;

   always_comb begin
      mask    = 8'hFF >> (4'd8 - ctl.chunk.size);
      ext     = (rd_data >> ctl.chunk.off) & mask;
      wr_en   = ctl.chunk.valid && ctl.chunk.is_write;
      // fresh bytes take the chunk alone
      wr_data = (ctl.chunk.fresh ? 8'd0 : rd_data) | ctl.chunk.piece;
      acc_in  = acc_ff;
      if (ctl.acc_clear) begin
         acc_in = 64'd0;
      end else if (ctl.chunk.valid && !ctl.chunk.is_write) begin
         acc_in = (acc_ff << ctl.chunk.size) | {56'd0, ext};
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
   end

   assign acc = acc_ff;

endmodule

>>> rtl/core/bitstream_field_packer.sv
// ============================================================================
// bitstream_field_packer: byte store with a bit cursor
// Packs and unpacks fields of 1 to 64 bits, clears, seeks and aligns.
// ============================================================================
// Usage:
//   The req_ channel carries one command per transaction; the rsp_ channel
//   returns exactly one result transaction per command, in order.
//   A write or read field is cut into chunks, one per byte touched, most
//   significant chunk first; each chunk fills its byte upward from the cursor.
//   Steps from acceptance to result: clear, seek, align, zero width and
//   rejected write or read pass through start and done; a write or read
//   touching N bytes (N = 1..9) runs one byte per run step, then drain, done.
//   One command at a time: req_stall holds while a command is in progress,
//   and the next command is taken once the block returns to idle.
//   A field's walk is paced by the store: one byte read per cycle, with the
//   read-modify-write of each byte overlapped with the next read.
//   Reset clears the cursor and stored length; store contents stay undefined
//   until written and need no clearing pass.
//   A stalled result holds in the output register while the next command is
//   accepted; that command waits in its final step until the register frees.
// ============================================================================
module bitstream_field_packer #(
   parameter int BUFFER_BYTES = 4096
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [6:0]  req_field_width,
   input  logic [63:0] req_write_value,
   input  logic [14:0] req_seek_position,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [63:0] rsp_read_value,
   output logic [15:0] rsp_bit_position,
   output logic [12:0] rsp_stored_bytes,
   output logic [1:0]  rsp_status
);
   import bfp_pkg::*;

   localparam int ADDR_W  = (BUFFER_BYTES > 1) ? $clog2(BUFFER_BYTES) : 1;
   // seek can place the cursor past a small store, so size for both
   localparam int PTR_MAX = (BUFFER_BYTES > 4096) ? BUFFER_BYTES : 4096;
   localparam int PTR_W   = $clog2(PTR_MAX + 1);
   localparam int CUR_W   = PTR_W + 3;
   localparam int CMP_W   = CUR_W + 1;
   localparam int LEN_W   = $clog2(BUFFER_BYTES + 1);
   localparam logic [CMP_W-1:0] LIMIT_BITS = CMP_W'(BUFFER_BYTES * 8);

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_START = 5'b00010,
      ST_RUN   = 5'b00100,
      ST_DRAIN = 5'b01000,
      ST_DONE  = 5'b10000
   } state_type;

   // control state
   state_type        state_ff, state_in;
   logic [PTR_W-1:0] bp_ff, bp_in;
   logic [2:0]       off_ff, off_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             chunk_valid_ff, chunk_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // command and walk registers
   cmd_type          cmd_ff, cmd_in;
   logic [6:0]       width_ff, width_in;
   logic [63:0]      value_ff, value_in;
   logic [14:0]      seek_ff, seek_in;
   logic [PTR_W-1:0] wbp_ff, wbp_in;
   logic [2:0]       woff_ff, woff_in;
   logic [6:0]       left_ff, left_in;
   logic [63:0]      vsh_ff, vsh_in;
   logic             is_wr_ff, is_wr_in;
   logic [LEN_W-1:0] need_ff, need_in;
   logic [1:0]       status_ff, status_in;
   logic             rd_ok_ff, rd_ok_in;
   chunk_type        chunk_ff, chunk_in;
   logic [ADDR_W-1:0] chunk_addr_ff, chunk_addr_in;

   // result register
   logic [63:0]      rsp_read_value_ff, rsp_read_value_in;
   logic [15:0]      rsp_bit_position_ff, rsp_bit_position_in;
   logic [12:0]      rsp_stored_bytes_ff, rsp_stored_bytes_in;
   logic [1:0]       rsp_status_ff, rsp_status_in;

   // combinational helpers
   logic              req_accept;
   logic              acc_clear;
   logic [CUR_W-1:0]  cursor;
   logic [CMP_W-1:0]  end_bits;
   logic [CMP_W-1:0]  len_bits;
   logic [CMP_W-1:0]  need_full;
   logic [PTR_W-1:0]  seek_bp;
   logic [3:0]        room;
   logic [3:0]        step;
   logic [3:0]        off_sum;
   logic [7:0]        piece_shr;
   logic [CUR_W-1:0]  commit_cursor;
   logic [LEN_W+12:0] len_ext;

   // store and byte unit
   logic              ram_rd_en;
   logic [ADDR_W-1:0] ram_rd_addr;
   logic [7:0]        ram_rd_data;
   logic              ram_wr_en;
   logic [7:0]        ram_wr_data;
   logic [63:0]       acc;
   byte_ctl_type      byte_ctl;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;

   assign cursor    = {bp_ff, off_ff};
   assign end_bits  = CMP_W'(cursor) + CMP_W'(width_ff);
   assign len_bits  = CMP_W'({len_ff, 3'b000});
   assign need_full = (end_bits + CMP_W'(7)) >> 3;
   assign seek_bp   = PTR_W'(seek_ff[14:3]);

   // chunk size: what is left of the field, capped by room in the byte
   assign room      = 4'd8 - {1'b0, woff_ff};
   assign step      = (left_ff < {3'b000, room}) ? left_ff[3:0] : room;
   assign off_sum   = {1'b0, woff_ff} + step;
   assign piece_shr = vsh_ff[63:56] >> (4'd8 - step);

   assign commit_cursor = {bp_ff, off_ff};
   assign len_ext       = {13'd0, len_ff};

   always_comb begin
      state_in            = state_ff;
      bp_in               = bp_ff;
      off_in              = off_ff;
      len_in              = len_ff;
      chunk_valid_in      = 1'b0;
      rsp_valid_in        = rsp_valid_ff && rsp_stall;
      cmd_in              = cmd_ff;
      width_in            = width_ff;
      value_in            = value_ff;
      seek_in             = seek_ff;
      wbp_in              = wbp_ff;
      woff_in             = woff_ff;
      left_in             = left_ff;
      vsh_in              = vsh_ff;
      is_wr_in            = is_wr_ff;
      need_in             = need_ff;
      status_in           = status_ff;
      rd_ok_in            = rd_ok_ff;
      chunk_in            = chunk_ff;
      chunk_in.valid      = 1'b0;
      chunk_addr_in       = chunk_addr_ff;
      rsp_read_value_in   = rsp_read_value_ff;
      rsp_bit_position_in = rsp_bit_position_ff;
      rsp_stored_bytes_in = rsp_stored_bytes_ff;
      rsp_status_in       = rsp_status_ff;
      acc_clear           = 1'b0;
      ram_rd_en           = 1'b0;
      ram_rd_addr         = wbp_ff[ADDR_W-1:0];

      case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               cmd_in   = cmd_type'(req_command);
               width_in = (req_field_width > 7'd64) ? 7'd64 : req_field_width;
               value_in = req_write_value;
               seek_in  = req_seek_position;
               state_in = ST_START;
            end
         end
         ST_START: begin
            status_in = STATUS_OK;
            rd_ok_in  = 1'b0;
            state_in  = ST_DONE;
            wbp_in    = bp_ff;
            woff_in   = off_ff;
            left_in   = width_ff;
            need_in   = LEN_W'(need_full);
            case (cmd_ff)
               CMD_CLEAR: begin
                  bp_in  = '0;
                  off_in = 3'd0;
                  len_in = '0;
               end
               CMD_WRITE: begin
                  if (width_ff != 7'd0) begin
                     if (end_bits > LIMIT_BITS) begin
                        status_in = STATUS_WRITE_OVF;
                     end else begin
                        // left-align the field so each chunk comes off the top
                        vsh_in   = value_ff << 6'(7'd64 - width_ff);
                        is_wr_in = 1'b1;
                        state_in = ST_RUN;
                     end
                  end
               end
               CMD_READ: begin
                  if (width_ff != 7'd0) begin
                     if (end_bits > len_bits) begin
                        status_in = STATUS_READ_PAST;
                     end else begin
                        is_wr_in  = 1'b0;
                        rd_ok_in  = 1'b1;
                        acc_clear = 1'b1;
                        state_in  = ST_RUN;
                     end
                  end
               end
               CMD_SEEK: begin
                  bp_in  = seek_bp;
                  off_in = seek_ff[2:0];
                  if (seek_bp >= PTR_W'(len_ff)) begin
                     status_in = STATUS_SEEK_PAST;
                  end
               end
               CMD_ALIGN: begin
                  if (off_ff != 3'd0) begin
                     off_in = 3'd0;
                     bp_in  = bp_ff + PTR_W'(1);
                  end
               end
               default: begin
               end
            endcase
         end
         ST_RUN: begin
            // issue the read for this byte; the merge happens next cycle
            ram_rd_en         = 1'b1;
            chunk_valid_in    = 1'b1;
            chunk_in.valid    = 1'b1;
            chunk_in.is_write = is_wr_ff;
            chunk_in.fresh    = (wbp_ff >= PTR_W'(len_ff));
            chunk_in.off      = woff_ff;
            chunk_in.size     = step;
            chunk_in.piece    = piece_shr << woff_ff;
            chunk_addr_in     = wbp_ff[ADDR_W-1:0];
            left_in           = left_ff - {3'b000, step};
            vsh_in            = vsh_ff << step;
            if (off_sum[3]) begin
               woff_in = 3'd0;
               wbp_in  = wbp_ff + PTR_W'(1);
            end else begin
               woff_in = off_sum[2:0];
            end
            if (left_in == 7'd0) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            // last byte merges now; commit the cursor and length
            bp_in  = wbp_ff;
            off_in = woff_ff;
            if (is_wr_ff && (need_ff > len_ff)) begin
               len_in = need_ff;
            end
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in        = 1'b1;
               rsp_read_value_in   = rd_ok_ff ? acc : 64'd0;
               rsp_bit_position_in = commit_cursor[15:0];
               rsp_stored_bytes_in = len_ext[12:0];
               rsp_status_in       = status_ff;
               state_in            = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         bp_ff          <= '0;
         off_ff         <= 3'd0;
         len_ff         <= '0;
         chunk_valid_ff <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bp_ff          <= bp_in;
         off_ff         <= off_in;
         len_ff         <= len_in;
         chunk_valid_ff <= chunk_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff              <= cmd_in;
      width_ff            <= width_in;
      value_ff            <= value_in;
      seek_ff             <= seek_in;
      wbp_ff              <= wbp_in;
      woff_ff             <= woff_in;
      left_ff             <= left_in;
      vsh_ff              <= vsh_in;
      is_wr_ff            <= is_wr_in;
      need_ff             <= need_in;
      status_ff           <= status_in;
      rd_ok_ff            <= rd_ok_in;
      chunk_ff            <= chunk_in;
      chunk_addr_ff       <= chunk_addr_in;
      rsp_read_value_ff   <= rsp_read_value_in;
      rsp_bit_position_ff <= rsp_bit_position_in;
      rsp_stored_bytes_ff <= rsp_stored_bytes_in;
      rsp_status_ff       <= rsp_status_in;
   end

   // the chunk's own valid is gated by the reset-cleared copy
   always_comb begin
      byte_ctl             = '0;
      byte_ctl.acc_clear   = acc_clear;
      byte_ctl.chunk       = chunk_ff;
      byte_ctl.chunk.valid = chunk_valid_ff;
   end

   bfp_ram #(
      .WIDTH (8),
      .DEPTH (BUFFER_BYTES)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (chunk_addr_ff),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bfp_byte_unit u_byte (
      .clock   (clock),
      .ctl     (byte_ctl),
      .rd_data (ram_rd_data),
      .wr_en   (ram_wr_en),
      .wr_data (ram_wr_data),
      .acc     (acc)
   );

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_value   = rsp_read_value_ff;
   assign rsp_bit_position = rsp_bit_position_ff;
   assign rsp_stored_bytes = rsp_stored_bytes_ff;
   assign rsp_status       = rsp_status_ff;

   // write-back and the next read never hit the same byte
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (ram_wr_en && ram_rd_en) |-> (chunk_addr_ff != ram_rd_addr))
      else $error("store write and read address collide");

   // a merge follows only a chunk issue
   a_chunk_after_run: assert property (@(posedge clock) disable iff (reset)
      chunk_valid_ff |-> $past(state_ff == ST_RUN))
      else $error("chunk merge without issue");

   // stored length stays within the store
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (len_ff <= LEN_W'(BUFFER_BYTES)))
      else $error("stored length beyond store");

   // failed commands return zero data
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != STATUS_OK)) |-> (rsp_read_value == 64'd0))
      else $error("nonzero data on error status");

endmodule
